FILE: rtl/fcpa_pkg.sv
// Package for the fixed chunk pool allocator: sizes, command, status and
// register codes, and the chunk count function. No dependencies.
package fcpa_pkg;

    localparam int MAX_CHUNKS = 1024;
    localparam int ADDR_BITS  = 48;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int LINK_W     = $clog2(MAX_CHUNKS + 1);
    localparam int LOG_W      = 5;
    localparam int DATA_W     = 64;
    localparam int PADDR_W    = 5;

    localparam logic [LINK_W-1:0] NIL_INDEX = LINK_W'(MAX_CHUNKS);

    localparam logic [LOG_W-1:0] RST_CHUNK_LOG2 = 5'd6;
    localparam logic [LOG_W-1:0] RST_POOL_LOG2  = 5'd16;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REINIT = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NULL     = 2'd1,
        ST_ABORT    = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_POOL_BASE  = 2'd0,
        REG_CHUNK_LOG2 = 2'd1,
        REG_POOL_LOG2  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    // 2^(pool - chunk), saturated at MAX_CHUNKS; zero when pool < chunk
    function automatic logic [LINK_W-1:0] chunk_count(input logic [LOG_W-1:0] chunk_log2,
                                                      input logic [LOG_W-1:0] pool_log2);
        logic [LOG_W-1:0] diff;
        logic [63:0]      n;
        diff = pool_log2 - chunk_log2;
        n    = 64'd1 << diff;
        if (pool_log2 < chunk_log2)
            return '0;
        else if (n > 64'(MAX_CHUNKS))
            return NIL_INDEX;
        else
            return LINK_W'(n);
    endfunction

endpackage

FILE: rtl/fixed_chunk_pool_allocator.sv
// Fixed chunk pool allocator: LIFO free list in a synchronous link memory,
// lazy rebuild through a fresh-chunk counter, APB register port.
// Depends on fcpa_pkg.

// Every command (allocate, free, reinitialize) runs in an accept step and an
// execute step: the accept step takes it and launches the read of the link
// memory at the list head, the execute step uses the registered read data,
// updates head and fresh count, writes back the link of a freed chunk and loads
// the response register. A response waiting on a stalled output does not block
// acceptance of the next command; the next command waits in its execute step
// until the output register frees. The link memory needs no clearing after
// reset: an entry is only used after a free wrote it.
module fixed_chunk_pool_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [1:0]                     command,
    input  logic [fcpa_pkg::ADDR_BITS-1:0] chunk_address,
    input  logic                           zero_fill,
    input  logic                           null_if_empty,
    // response channel
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [1:0]                     status,
    output logic [fcpa_pkg::ADDR_BITS-1:0] granted_address,
    output logic                           clear_chunk,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fcpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [fcpa_pkg::DATA_W-1:0]    pwdata,
    output logic [fcpa_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import fcpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    localparam logic [LINK_W-1:0] RST_FRESH = chunk_count(RST_CHUNK_LOG2, RST_POOL_LOG2);

    state_t                state_reg, state_next;
    logic [ADDR_BITS-1:0]  base_reg;
    logic [LOG_W-1:0]      chunk_log2_reg;
    logic [LOG_W-1:0]      pool_log2_reg;
    logic [LINK_W-1:0]     head_reg, head_next;
    logic [LINK_W-1:0]     fresh_reg, fresh_next;
    cmd_t                  cmd_reg;
    logic                  zfill_reg;
    logic                  nullf_reg;
    logic [ADDR_BITS-1:0]  off_reg;

    logic [LINK_W-1:0]     link_mem [MAX_CHUNKS];
    logic [LINK_W-1:0]     link_rdata;

    logic                  rsp_valid_reg;
    status_t               status_reg, status_next;
    logic [ADDR_BITS-1:0]  granted_reg, granted_next;
    logic                  clear_reg, clear_next;

    logic                  accept;
    logic                  cfg_write;
    reg_idx_t              reg_idx;
    logic                  out_free;
    logic                  finish;
    logic [LINK_W-1:0]     count;
    logic [ADDR_BITS-1:0]  shifted;
    logic [ADDR_BITS-1:0]  low_mask;
    logic                  free_ok;
    logic [IDX_W-1:0]      wr_idx;
    logic                  mem_we;
    logic [IDX_W-1:0]      grant_idx;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign finish    = (state_reg == S_EXEC) && out_free;

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign granted_address = granted_reg;
    assign clear_chunk     = clear_reg;

    // register port
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_POOL_BASE:  prdata = DATA_W'(base_reg);
            REG_CHUNK_LOG2: prdata = DATA_W'(chunk_log2_reg);
            REG_POOL_LOG2:  prdata = DATA_W'(pool_log2_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            chunk_log2_reg <= RST_CHUNK_LOG2;
            pool_log2_reg  <= RST_POOL_LOG2;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_POOL_BASE:  base_reg       <= pwdata[ADDR_BITS-1:0];
                REG_CHUNK_LOG2: chunk_log2_reg <= pwdata[LOG_W-1:0];
                REG_POOL_LOG2:  pool_log2_reg  <= pwdata[LOG_W-1:0];
                default:        ;
            endcase
        end
    end

    // free address check
    assign count    = chunk_count(chunk_log2_reg, pool_log2_reg);
    assign shifted  = off_reg >> chunk_log2_reg;
    assign low_mask = ~({ADDR_BITS{1'b1}} << chunk_log2_reg);
    assign free_ok  = ((off_reg & low_mask) == '0) && (shifted < ADDR_BITS'(count));
    assign wr_idx   = shifted[IDX_W-1:0];
    assign mem_we   = finish && (cmd_reg == CMD_FREE) && free_ok;

    // link memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[wr_idx] <= head_reg;
        if (accept)
            link_rdata <= link_mem[head_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        head_next    = head_reg;
        fresh_next   = fresh_reg;
        status_next  = ST_OK;
        granted_next = '0;
        clear_next   = 1'b0;
        grant_idx    = '0;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                if (head_reg != NIL_INDEX)
                begin
                    grant_idx    = head_reg[IDX_W-1:0];
                    head_next    = link_rdata;
                    granted_next = base_reg + (ADDR_BITS'(grant_idx) << chunk_log2_reg);
                    clear_next   = zfill_reg;
                end
                else if (fresh_reg != '0)
                begin
                    fresh_next   = fresh_reg - LINK_W'(1);
                    grant_idx    = fresh_next[IDX_W-1:0];
                    granted_next = base_reg + (ADDR_BITS'(grant_idx) << chunk_log2_reg);
                    clear_next   = zfill_reg;
                end
                else
                begin
                    status_next = nullf_reg ? ST_NULL : ST_ABORT;
                end
            end
            CMD_FREE:
            begin
                if (free_ok)
                    head_next = LINK_W'(wr_idx);
                else
                    status_next = ST_BAD_FREE;
            end
            CMD_REINIT:
            begin
                head_next  = NIL_INDEX;
                fresh_next = count;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_EXEC;
            S_EXEC: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL_INDEX;
            fresh_reg     <= RST_FRESH;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                head_reg      <= head_next;
                fresh_reg     <= fresh_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(command);
            zfill_reg <= zero_fill;
            nullf_reg <= null_if_empty;
            off_reg   <= chunk_address - base_reg;
        end
        if (finish)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            clear_reg   <= clear_next;
        end
    end

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= NIL_INDEX)
        else $error("list head beyond null marker");

    a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= NIL_INDEX)
        else $error("fresh count beyond pool maximum");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC) && cmd_stall)
        else $error("accepted word not held in execute");

    a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> head_reg == LINK_W'($past(wr_idx)))
        else $error("freed chunk did not become list head");

endmodule

FILE: bench/testbench.sv
// Testbench for fixed_chunk_pool_allocator: directed table, then random phases over
// several pool settings, every response checked against the table's expected value
// or an in-bench free-list predictor. Depends on fcpa_pkg and the RTL top only.
module testbench;
    import fcpa_pkg::*;

    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_BITS-1:0] addr;
        logic              zf;
        logic              nf;
    } cmd_word_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_BITS-1:0] granted;
        logic              clear;
    } rsp_t;

    typedef struct packed {
        logic              is_cfg;
        reg_idx_t          sel;
        logic [DATA_W-1:0] value;
        cmd_word_t         word;
        rsp_t              want;
    } step_row_t;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF    = 250;
    localparam int N_PHASES    = 9;
    localparam int PHASE_WORDS = 50;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    logic [1:0]           command = CMD_NOP;
    logic [ADDR_BITS-1:0] chunk_address = '0;
    logic                 zero_fill = 1'b0;
    logic                 null_if_empty = 1'b0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] granted_address;
    logic                 clear_chunk;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    fixed_chunk_pool_allocator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .command         (command),
        .chunk_address   (chunk_address),
        .zero_fill       (zero_fill),
        .null_if_empty   (null_if_empty),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .granted_address (granted_address),
        .clear_chunk     (clear_chunk),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [ADDR_BITS-1:0] base_reg;
    logic [LOG_W-1:0]     chunk_log2_reg;
    logic [LOG_W-1:0]     pool_log2_reg;
    logic [LINK_W-1:0]    next_link [MAX_CHUNKS];
    logic [LINK_W-1:0]    free_head;
    logic [LINK_W-1:0]    fresh_left;

    rsp_t owed_rsp [$];
    int   tx_max = 0;
    int   rx_max = 0;
    int   rx_hold = 0;
    int   n_sent = 0;
    int   n_checked = 0;
    int   n_empty = 0;
    int   n_bad = 0;
    int   n_errors = 0;
    int   quiet_cycles = 0;

    function automatic int unsigned chunks_in_pool();
        logic [LOG_W-1:0] diff;
        logic [63:0]      n;
        if (pool_log2_reg < chunk_log2_reg)
            return 0;
        diff = pool_log2_reg - chunk_log2_reg;
        n = 64'd1 << diff;
        return (n > 64'(MAX_CHUNKS)) ? MAX_CHUNKS : int'(n);
    endfunction

    function automatic rsp_t response_to(cmd_word_t w);
        rsp_t                 r;
        logic [LINK_W-1:0]    slot;
        logic                 granted;
        logic [ADDR_BITS-1:0] off48;
        logic [63:0]          off;
        logic [63:0]          idx;
        logic [63:0]          full;
        r = '0;
        r.status = ST_OK;
        granted = 1'b0;
        slot = '0;
        case (w.cmd)
            CMD_ALLOC:
            begin
                if (free_head != NIL_INDEX)
                begin
                    slot = free_head;
                    free_head = next_link[free_head[IDX_W-1:0]];
                    granted = 1'b1;
                end
                else if (fresh_left != 0)
                begin
                    fresh_left = fresh_left - LINK_W'(1);
                    slot = fresh_left;
                    granted = 1'b1;
                end
                else
                    r.status = w.nf ? ST_NULL : ST_ABORT;
                if (granted)
                begin
                    full = 64'(base_reg) + (64'(slot) << chunk_log2_reg);
                    r.granted = full[ADDR_BITS-1:0];
                    r.clear = w.zf;
                end
            end
            CMD_FREE:
            begin
                off48 = w.addr - base_reg;
                off = 64'(off48);
                idx = off >> chunk_log2_reg;
                if ((off & ((64'd1 << chunk_log2_reg) - 64'd1)) != 0
                    || idx >= 64'(chunks_in_pool()))
                    r.status = ST_BAD_FREE;
                else
                begin
                    next_link[idx[IDX_W-1:0]] = free_head;
                    free_head = LINK_W'(idx);
                end
            end
            CMD_REINIT:
            begin
                free_head = NIL_INDEX;
                fresh_left = LINK_W'(chunks_in_pool());
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic step_row_t cmd_row(cmd_t c, logic [ADDR_BITS-1:0] a, logic zf,
                                          logic nf, status_t s, logic [ADDR_BITS-1:0] g,
                                          logic clr);
        step_row_t row;
        row = '0;
        row.word = '{cmd: c, addr: a, zf: zf, nf: nf};
        row.want = '{status: s, granted: g, clear: clr};
        return row;
    endfunction

    function automatic step_row_t reg_row(reg_idx_t sel, logic [DATA_W-1:0] v);
        step_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.sel = sel;
        row.value = v;
        row.word.cmd = CMD_NOP;
        row.want.status = ST_OK;
        return row;
    endfunction

    task automatic send_word(cmd_word_t w, logic has_want, rsp_t want);
        int   gap;
        rsp_t pred;
        gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= w.cmd;
        chunk_address <= w.addr;
        zero_fill <= w.zf;
        null_if_empty <= w.nf;
        do @(posedge clk); while (cmd_stall);
        pred = response_to(w);
        owed_rsp.push_back(has_want ? want : pred);
        n_sent++;
    endtask

    task automatic wait_for_responses();
        cmd_valid <= 1'b0;
        while (owed_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t sel, logic [DATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({sel, 3'b000});
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_POOL_BASE:  base_reg = v[ADDR_BITS-1:0];
            REG_CHUNK_LOG2: chunk_log2_reg = v[LOG_W-1:0];
            REG_POOL_LOG2:  pool_log2_reg = v[LOG_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic check_response();
        rsp_t want;
        if (owed_rsp.size() == 0)
        begin
            $error("unexpected word: status %0d, granted_address %h", status, granted_address);
            n_errors++;
            return;
        end
        want = owed_rsp.pop_front();
        n_checked++;
        if (want.status == ST_NULL || want.status == ST_ABORT)
            n_empty++;
        if (want.status == ST_BAD_FREE)
            n_bad++;
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            n_errors++;
        end
        if (granted_address !== want.granted)
        begin
            $error("granted_address: expected %h, got %h", want.granted, granted_address);
            n_errors++;
        end
        if (clear_chunk !== want.clear)
        begin
            $error("clear_chunk: expected %0d, got %0d", want.clear, clear_chunk);
            n_errors++;
        end
    endtask

    // response side
    initial
    begin
        int k;
        wait (rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                k = rx_hold;
                rx_hold = 0;
            end
            else
                k = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
            if (k > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            check_response();
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        step_row_t    directed_steps [31];
        int unsigned  chunk_set [N_PHASES] = '{6, 4, 16, 4, 31, 0, 10, 12, 5};
        int unsigned  pool_set [N_PHASES]  = '{16, 5, 26, 8, 31, 3, 9, 26, 8};
        int           gap_caps [3] = '{0, 3, 18};
        logic [63:0]  r64;
        logic [63:0]  full;
        logic [ADDR_BITS-1:0] base_pick;
        cmd_word_t    w;
        int unsigned  cnt;
        int unsigned  roll;

        base_reg = '0;
        chunk_log2_reg = RST_CHUNK_LOG2;
        pool_log2_reg = RST_POOL_LOG2;
        free_head = NIL_INDEX;
        fresh_left = LINK_W'(chunks_in_pool());

        directed_steps = '{
            cmd_row(CMD_ALLOC,  48'h0,              1, 0, ST_OK,       48'hFFC0, 1),
            cmd_row(CMD_ALLOC,  48'h0,              0, 1, ST_OK,       48'hFF80, 0),
            cmd_row(CMD_FREE,   48'hFFC0,           1, 1, ST_OK,       48'h0,    0),
            cmd_row(CMD_FREE,   48'h0,              0, 0, ST_OK,       48'h0,    0),
            cmd_row(CMD_ALLOC,  48'hFFFF_FFFF_FFFF, 1, 0, ST_OK,       48'h0,    1),
            cmd_row(CMD_FREE,   48'h1,              0, 0, ST_BAD_FREE, 48'h0,    0),
            cmd_row(CMD_FREE,   48'h1_0000,         0, 0, ST_BAD_FREE, 48'h0,    0),
            cmd_row(CMD_FREE,   48'hFFFF_FFFF_FFFF, 0, 0, ST_BAD_FREE, 48'h0,    0),
            cmd_row(CMD_NOP,    48'hFFFF_FFFF_FFFF, 1, 1, ST_OK,       48'h0,    0),
            cmd_row(CMD_REINIT, 48'hFFFF_FFFF_FFFF, 1, 1, ST_OK,       48'h0,    0),
            reg_row(REG_POOL_LOG2, 64'hFFFF_FFFF_FFFF_FFE7),
            cmd_row(CMD_FREE,   48'h40,             0, 0, ST_OK,       48'h0,    0),
            cmd_row(CMD_FREE,   48'h80,             0, 0, ST_BAD_FREE, 48'h0,    0),
            cmd_row(CMD_REINIT, 48'h0,              0, 0, ST_OK,       48'h0,    0),
            cmd_row(CMD_ALLOC,  48'h0,              0, 0, ST_OK,       48'h40,   0),
            cmd_row(CMD_ALLOC,  48'h0,              0, 0, ST_OK,       48'h0,    0),
            cmd_row(CMD_ALLOC,  48'h0,              0, 1, ST_NULL,     48'h0,    0),
            cmd_row(CMD_ALLOC,  48'h0,              1, 0, ST_ABORT,    48'h0,    0),
            reg_row(REG_POOL_LOG2, 64'd5),
            cmd_row(CMD_FREE,   48'h0,              0, 0, ST_BAD_FREE, 48'h0,    0),
            cmd_row(CMD_REINIT, 48'h0,              0, 0, ST_OK,       48'h0,    0),
            cmd_row(CMD_ALLOC,  48'h0,              1, 1, ST_NULL,     48'h0,    0),
            reg_row(REG_POOL_BASE, 64'hFFFF_FFFF_FFFF_FFE0),
            reg_row(REG_CHUNK_LOG2, 64'd4),
            reg_row(REG_POOL_LOG2, 64'd6),
            cmd_row(CMD_REINIT, 48'h0,              0, 0, ST_OK,       48'h0,    0),
            cmd_row(CMD_ALLOC,  48'h0,              0, 0, ST_OK,       48'h10,   0),
            cmd_row(CMD_ALLOC,  48'h0,              0, 0, ST_OK,       48'h0,    0),
            cmd_row(CMD_FREE,   48'h10,             0, 0, ST_OK,       48'h0,    0),
            cmd_row(CMD_FREE,   48'h20,             0, 0, ST_BAD_FREE, 48'h0,    0),
            cmd_row(CMD_ALLOC,  48'h0,              1, 0, ST_OK,       48'h10,   1)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_max = 18;
        rx_max = 18;
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_cfg)
            begin
                wait_for_responses();
                repeat (4) @(posedge clk);
                write_register(directed_steps[i].sel, directed_steps[i].value);
            end
            else
                send_word(directed_steps[i].word, 1'b1, directed_steps[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_for_responses();
            repeat (4) @(posedge clk);
            r64 = {$urandom, $urandom};
            base_pick = (p == 0) ? '0 : (p == 3) ? '1 : r64[ADDR_BITS-1:0];
            write_register(REG_POOL_BASE, {r64[63:ADDR_BITS], base_pick});
            r64 = {$urandom, $urandom};
            write_register(REG_CHUNK_LOG2, {r64[63:LOG_W], LOG_W'(chunk_set[p])});
            r64 = {$urandom, $urandom};
            write_register(REG_POOL_LOG2, {r64[63:LOG_W], LOG_W'(pool_set[p])});

            if (p == 0)
            begin
                tx_max = 0;
                rx_max = 0;
            end
            else if (p == 1)
            begin
                tx_max = 18;
                rx_max = 18;
            end
            else
            begin
                tx_max = gap_caps[$urandom_range(0, 2)];
                rx_max = gap_caps[$urandom_range(0, 2)];
            end
            // receiver backs off while words keep coming
            if (p == 2)
            begin
                tx_max = 0;
                rx_hold = HOLD_OFF;
            end

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 4 && n == PHASE_WORDS / 2)
                    wait_for_responses();
                cnt = chunks_in_pool();
                r64 = {$urandom, $urandom};
                w.addr = r64[ADDR_BITS-1:0];
                w.zf = 1'($urandom_range(0, 1));
                w.nf = 1'($urandom_range(0, 1));
                roll = (n == 0 && $urandom_range(0, 1)) ? 92 : $urandom_range(0, 99);
                if (roll < 45)
                    w.cmd = CMD_ALLOC;
                else if (roll < 90)
                begin
                    w.cmd = CMD_FREE;
                    if (cnt > 0)
                    begin
                        full = 64'(base_reg)
                               + (64'($urandom_range(0, cnt - 1)) << chunk_log2_reg);
                        if (roll < 80)
                            w.addr = full[ADDR_BITS-1:0];
                        else if (roll < 85 && chunk_log2_reg != 0)
                        begin
                            full = full + 64'($urandom_range(1,
                                       (32'd1 << chunk_log2_reg) - 32'd1));
                            w.addr = full[ADDR_BITS-1:0];
                        end
                        else if (roll < 88)
                        begin
                            full = 64'(base_reg) + (64'(cnt) << chunk_log2_reg);
                            w.addr = full[ADDR_BITS-1:0];
                        end
                    end
                end
                else if (roll < 95)
                    w.cmd = CMD_REINIT;
                else
                    w.cmd = CMD_NOP;
                send_word(w, 1'b0, '0);
            end
        end

        wait_for_responses();
        repeat (10) @(posedge clk);
        $display("Sent %0d words over %0d pool settings, %0d responses checked,",
                 n_sent, N_PHASES + 4, n_checked);
        $display("including %0d empty-pool and %0d bad-free responses.", n_empty, n_bad);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
